### rtl/gvmd_pkg.sv
package gvmd_pkg;

   // Per-cell level word: 0 for a valued cell, p+1 for a cell reached in pass p,
   // all ones for a cell that no pass has reached.
   localparam int LVL_W = 7;
   localparam logic [LVL_W-1:0] LVL_VALUED = '0;
   localparam logic [LVL_W-1:0] LVL_NONE   = '1;

   localparam int CNT_W = 11;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [1:0] CLS_COPY = 2'd0;
   localparam logic [1:0] CLS_FILL = 2'd1;
   localparam logic [1:0] CLS_EST  = 2'd2;

   localparam logic [1:0] CSR_SIZE_X = 2'd0;
   localparam logic [1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [1:0] CSR_SIZE_Z = 2'd2;
   localparam logic [1:0] CSR_STEPS  = 2'd3;

   typedef struct packed {
      logic load_we;
      logic read_rd;
      logic rsp_cap;
      logic scan_init;
      logic own_rd;
      logic nb_init;
      logic nb_step;
      logic cell_fin;
      logic cell_next;
   } cmd_type;

   typedef struct packed {
      logic rsp_busy;
      logic full;
      logic load_last;
      logic steps_zero;
      logic own_none;
      logic offs_last;
      logic pass_done;
   } sts_type;

endpackage

### rtl/grid_void_mask_dilation_3d.sv
// Void mask dilation over a 3D grid of up to MAX_X * MAX_Y * MAX_Z cells.
// Requests (req_valid/req_ready) carry req_cmd and req_cell_valued. A load
// request stores the next cell flag in raster order, i fastest; a load
// beyond the grid is dropped. Loads are taken one per cycle while no
// response waits. Accepting the final load starts the dilation, unless
// dilation_steps is 0: each pass visits every cell, and an unreached
// cell reads its clipped 26-cell neighborhood one memory word per cycle
// after its own word is read; a cell that holds a level is passed over.
// Passes stop after dilation_steps or after a pass that reaches nothing
// new; requests are held off meanwhile. A readout request returns one
// response (rsp_valid/rsp_ready); rsp_valid is registered and rises after
// the ST_RWAIT state, carrying the cell class and a flag on the final cell.
// A readout before the grid is loaded returns nothing. No request is taken
// in ST_RWAIT. While a response waits for rsp_ready no request is taken.
// Reset sets the sizes to 1, dilation_steps to 0 and both positions to 0.
// Writing a size register restarts the grid; cell memory is not cleared.
module grid_void_mask_dilation_3d #(
   parameter int MAX_X = 64,
   parameter int MAX_Y = 64,
   parameter int MAX_Z = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [6:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic       req_cell_valued,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_cell_class,
   output logic       rsp_last_cell
);
   import gvmd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   gvmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .sts       (sts),
      .cmd       (cmd)
   );

   gvmd_dp #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cell_valued (req_cell_valued),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cell_class  (rsp_cell_class),
      .rsp_last_cell   (rsp_last_cell)
   );
endmodule

### rtl/gvmd_ram.sv
module gvmd_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### rtl/gvmd_ctrl.sv
module gvmd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_cmd,
   input  gvmd_pkg::sts_type sts,
   output gvmd_pkg::cmd_type cmd
);
   import gvmd_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_RWAIT  = 3'd1;
   localparam logic [2:0] ST_OWN    = 3'd2;
   localparam logic [2:0] ST_OWNCHK = 3'd3;
   localparam logic [2:0] ST_NB     = 3'd4;
   localparam logic [2:0] ST_NBEND  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       acc;

   assign req_ready = (state_ff == ST_IDLE) && !sts.rsp_busy;
   assign acc = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               if (req_cmd == CMD_LOAD) begin
                  if (!sts.full) begin
                     cmd.load_we = 1'b1;
                     if (sts.load_last && !sts.steps_zero) begin
                        cmd.scan_init = 1'b1;
                        state_in = ST_OWN;
                     end
                  end
               end else if (sts.full) begin
                  cmd.read_rd = 1'b1;
                  state_in = ST_RWAIT;
               end
            end
         end
         ST_RWAIT: begin
            cmd.rsp_cap = 1'b1;
            state_in = ST_IDLE;
         end
         ST_OWN: begin
            cmd.own_rd = 1'b1;
            state_in = ST_OWNCHK;
         end
         ST_OWNCHK: begin
            if (sts.own_none) begin
               cmd.nb_init = 1'b1;
               state_in = ST_NB;
            end else begin
               cmd.cell_next = 1'b1;
               state_in = sts.pass_done ? ST_IDLE : ST_OWN;
            end
         end
         ST_NB: begin
            cmd.nb_step = 1'b1;
            if (sts.offs_last) begin
               state_in = ST_NBEND;
            end
         end
         ST_NBEND: begin
            cmd.cell_fin = 1'b1;
            cmd.cell_next = 1'b1;
            state_in = sts.pass_done ? ST_IDLE : ST_OWN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

### rtl/gvmd_dp.sv
module gvmd_dp #(
   parameter int MAX_X = 64,
   parameter int MAX_Y = 64,
   parameter int MAX_Z = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [6:0]        csr_wdata,
   input  logic              req_cell_valued,
   input  gvmd_pkg::cmd_type  cmd,
   output gvmd_pkg::sts_type  sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_cell_class,
   output logic              rsp_last_cell
);
   import gvmd_pkg::*;

   localparam int XW = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int AW = XW + YW + ZW;

   logic [6:0] size_x_ff, size_y_ff;
   logic [4:0] size_z_ff;
   logic [5:0] steps_ff;
   logic [CNT_W-1:0] ex, ey, ez;

   logic [XW-1:0] li_ff, ri_ff, si_ff;
   logic [YW-1:0] lj_ff, rj_ff, sj_ff;
   logic [ZW-1:0] lk_ff, rk_ff, sk_ff;
   logic          full_ff;
   logic [5:0]    pass_ff;
   logic          changed_ff, hit_ff, pend_ff;
   logic [1:0]    oi_ff, oj_ff, ok_ff;
   logic          rsp_valid_ff, rsp_last_ff, last_pend_ff;
   logic [1:0]    rsp_class_ff;

   logic          load_end, read_end, cell_last, hit_now, changed_now;
   logic          nb_in;
   logic [XW-1:0] ni;
   logic [YW-1:0] nj;
   logic [ZW-1:0] nk;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [LVL_W-1:0] ram_wdata, rd_data;

   function automatic logic [CNT_W-1:0] clamp(input logic [CNT_W-1:0] v,
                                               input logic [CNT_W-1:0] m);
      logic [CNT_W-1:0] r;
      r = v;
      if (v == '0) r = CNT_W'(1);
      else if (v > m) r = m;
      return r;
   endfunction

   assign ex = clamp(CNT_W'(size_x_ff), CNT_W'(MAX_X));
   assign ey = clamp(CNT_W'(size_y_ff), CNT_W'(MAX_Y));
   assign ez = clamp(CNT_W'(size_z_ff), CNT_W'(MAX_Z));

   assign load_end = (CNT_W'(li_ff) == ex - 1'b1) && (CNT_W'(lj_ff) == ey - 1'b1)
                     && (CNT_W'(lk_ff) == ez - 1'b1);
   assign read_end = (CNT_W'(ri_ff) == ex - 1'b1) && (CNT_W'(rj_ff) == ey - 1'b1)
                     && (CNT_W'(rk_ff) == ez - 1'b1);
   assign cell_last = (CNT_W'(si_ff) == ex - 1'b1) && (CNT_W'(sj_ff) == ey - 1'b1)
                      && (CNT_W'(sk_ff) == ez - 1'b1);

   // Neighbor offset codes 0, 1, 2 stand for -1, 0, +1; clipped at the edges.
   assign nb_in = !((si_ff == '0) && (oi_ff == 2'd0))
                  && !((CNT_W'(si_ff) == ex - 1'b1) && (oi_ff == 2'd2))
                  && !((sj_ff == '0) && (oj_ff == 2'd0))
                  && !((CNT_W'(sj_ff) == ey - 1'b1) && (oj_ff == 2'd2))
                  && !((sk_ff == '0) && (ok_ff == 2'd0))
                  && !((CNT_W'(sk_ff) == ez - 1'b1) && (ok_ff == 2'd2));
   assign ni = XW'(CNT_W'(si_ff) + CNT_W'(oi_ff) - CNT_W'(1));
   assign nj = YW'(CNT_W'(sj_ff) + CNT_W'(oj_ff) - CNT_W'(1));
   assign nk = ZW'(CNT_W'(sk_ff) + CNT_W'(ok_ff) - CNT_W'(1));

   assign hit_now = hit_ff || (pend_ff && (rd_data <= LVL_W'(pass_ff)));
   assign changed_now = changed_ff || (cmd.cell_fin && hit_now);

   always_comb begin
      ram_we = 1'b0;
      ram_waddr = {lk_ff, lj_ff, li_ff};
      ram_wdata = req_cell_valued ? LVL_VALUED : LVL_NONE;
      if (cmd.load_we) begin
         ram_we = 1'b1;
      end else if (cmd.cell_fin && hit_now) begin
         ram_we = 1'b1;
         ram_waddr = {sk_ff, sj_ff, si_ff};
         ram_wdata = LVL_W'(pass_ff) + LVL_W'(1);
      end
      ram_re = cmd.read_rd || cmd.own_rd || (cmd.nb_step && nb_in);
      if (cmd.read_rd) ram_raddr = {rk_ff, rj_ff, ri_ff};
      else if (cmd.own_rd) ram_raddr = {sk_ff, sj_ff, si_ff};
      else ram_raddr = {nk, nj, ni};
   end

   gvmd_ram #(.WIDTH(LVL_W), .DEPTH(2 ** AW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= 7'd1;
         size_y_ff <= 7'd1;
         size_z_ff <= 5'd1;
         steps_ff <= '0;
         li_ff <= '0; lj_ff <= '0; lk_ff <= '0;
         ri_ff <= '0; rj_ff <= '0; rk_ff <= '0;
         full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SIZE_X: size_x_ff <= csr_wdata;
               CSR_SIZE_Y: size_y_ff <= csr_wdata;
               CSR_SIZE_Z: size_z_ff <= csr_wdata[4:0];
               CSR_STEPS:  steps_ff <= csr_wdata[5:0];
               default: ;
            endcase
            if (csr_index != CSR_STEPS) begin
               li_ff <= '0; lj_ff <= '0; lk_ff <= '0;
               ri_ff <= '0; rj_ff <= '0; rk_ff <= '0;
               full_ff <= 1'b0;
            end
         end
         if (cmd.load_we) begin
            if (load_end) begin
               full_ff <= 1'b1;
            end else if (CNT_W'(li_ff) != ex - 1'b1) begin
               li_ff <= li_ff + 1'b1;
            end else begin
               li_ff <= '0;
               if (CNT_W'(lj_ff) != ey - 1'b1) begin
                  lj_ff <= lj_ff + 1'b1;
               end else begin
                  lj_ff <= '0;
                  lk_ff <= lk_ff + 1'b1;
               end
            end
         end
         if (cmd.read_rd) begin
            if (read_end) begin
               full_ff <= 1'b0;
               li_ff <= '0; lj_ff <= '0; lk_ff <= '0;
               ri_ff <= '0; rj_ff <= '0; rk_ff <= '0;
            end else if (CNT_W'(ri_ff) != ex - 1'b1) begin
               ri_ff <= ri_ff + 1'b1;
            end else begin
               ri_ff <= '0;
               if (CNT_W'(rj_ff) != ey - 1'b1) begin
                  rj_ff <= rj_ff + 1'b1;
               end else begin
                  rj_ff <= '0;
                  rk_ff <= rk_ff + 1'b1;
               end
            end
         end
         if (cmd.rsp_cap) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan state and response payload.
   always_ff @(posedge clock) begin
      if (cmd.read_rd) begin
         last_pend_ff <= read_end;
      end
      if (cmd.rsp_cap) begin
         rsp_last_ff <= last_pend_ff;
         if (rd_data == LVL_VALUED) rsp_class_ff <= CLS_COPY;
         else if (rd_data == LVL_NONE) rsp_class_ff <= CLS_FILL;
         else rsp_class_ff <= CLS_EST;
      end
      if (cmd.scan_init) begin
         pass_ff <= '0;
         changed_ff <= 1'b0;
         si_ff <= '0; sj_ff <= '0; sk_ff <= '0;
      end
      if (cmd.nb_init) begin
         oi_ff <= '0; oj_ff <= '0; ok_ff <= '0;
         hit_ff <= 1'b0;
         pend_ff <= 1'b0;
      end
      if (cmd.nb_step) begin
         hit_ff <= hit_now;
         pend_ff <= nb_in;
         if (oi_ff != 2'd2) begin
            oi_ff <= oi_ff + 1'b1;
         end else begin
            oi_ff <= '0;
            if (oj_ff != 2'd2) begin
               oj_ff <= oj_ff + 1'b1;
            end else begin
               oj_ff <= '0;
               ok_ff <= ok_ff + 1'b1;
            end
         end
      end
      if (cmd.cell_next) begin
         if (cell_last) begin
            si_ff <= '0; sj_ff <= '0; sk_ff <= '0;
            pass_ff <= pass_ff + 1'b1;
            changed_ff <= 1'b0;
         end else begin
            changed_ff <= changed_now;
            if (CNT_W'(si_ff) != ex - 1'b1) begin
               si_ff <= si_ff + 1'b1;
            end else begin
               si_ff <= '0;
               if (CNT_W'(sj_ff) != ey - 1'b1) begin
                  sj_ff <= sj_ff + 1'b1;
               end else begin
                  sj_ff <= '0;
                  sk_ff <= sk_ff + 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      sts.rsp_busy   = rsp_valid_ff;
      sts.full       = full_ff;
      sts.load_last  = load_end;
      sts.steps_zero = (steps_ff == '0);
      sts.own_none   = (rd_data == LVL_NONE);
      sts.offs_last  = (oi_ff == 2'd2) && (oj_ff == 2'd2) && (ok_ff == 2'd2);
      sts.pass_done  = cell_last && (!changed_now || (6'(pass_ff + 1'b1) == steps_ff));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cell_class = rsp_class_ff;
   assign rsp_last_cell = rsp_last_ff;

   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.rsp_cap))
      else $error("response raised without a readout");
   a_scan_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.own_rd |-> full_ff && (pass_ff < steps_ff))
      else $error("dilation scan outside a loaded grid");
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      cmd.load_we |-> !cmd.cell_fin && !cmd.nb_step)
      else $error("load collides with dilation");
endmodule
